[rtl/core/fbc_pkg.sv]
//------------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the 64-bit Feistel block cipher
// Holds the substitution table, the round function and the pipeline stage type.
//------------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

   localparam int WORD_W    = 32;
   localparam int KEY_COUNT = 8;
   localparam int KEY_IDX_W = 3;
   localparam int ROT_LEFT  = 11;

   // Eight 4-bit S-boxes
   localparam logic [3:0] SBOX_TABLE [KEY_COUNT][16] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd15, 4'd3,  4'd7,  4'd0,  4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd10, 4'd7,
        4'd3,  4'd15, 4'd5,  4'd6,  4'd9,  4'd0,  4'd11, 4'd14},
      '{4'd10, 4'd5,  4'd15, 4'd6,  4'd12, 4'd11, 4'd3,  4'd14,
        4'd7,  4'd13, 4'd8,  4'd0,  4'd9,  4'd4,  4'd1,  4'd2},
      '{4'd9,  4'd7,  4'd12, 4'd8,  4'd5,  4'd14, 4'd3,  4'd0,
        4'd6,  4'd2,  4'd10, 4'd1,  4'd11, 4'd13, 4'd4,  4'd15},
      '{4'd4,  4'd10, 4'd7,  4'd12, 4'd0,  4'd15, 4'd2,  4'd8,
        4'd14, 4'd1,  4'd6,  4'd5,  4'd13, 4'd11, 4'd9,  4'd3},
      '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
        4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3}
   };

   // One pipeline slot: block halves travel with their mode and valid bit
   typedef struct packed {
      logic              valid;
      logic              func;
      logic [WORD_W-1:0] n1;
      logic [WORD_W-1:0] n2;
   } stage_type;

   // Round function: add key, substitute nibbles, rotate left
   function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] half,
                                                 input logic [WORD_W-1:0] kw);
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] sub;
      logic [7:0]        byte_val;
      sum = half + kw;
      sub = '0;
      // High nibble of byte b uses box 2b, low nibble box 2b+1
      for (int b = 0; b < 4; b++) begin
         byte_val          = sum[8*b +: 8];
         sub[8*b + 4 +: 4] = SBOX_TABLE[2*b][byte_val[7:4]];
         sub[8*b +: 4]     = SBOX_TABLE[2*b + 1][byte_val[3:0]];
      end
      return (sub << ROT_LEFT) | (sub >> (WORD_W - ROT_LEFT));
   endfunction

endpackage

`default_nettype wire

[rtl/core/feistel_64bit_block_cipher_top.sv]
//------------------------------------------------------------------------------
// feistel_64bit_block_cipher_top: pipelined 64-bit Feistel block cipher
//
// Blocks enter on the req_ stream (tdata = block, tuser = mode, 0 encrypt,
// 1 decrypt) and leave on the rsp_ stream in the same order, one result per
// block. The 256-bit key is held in eight 32-bit words that the user writes
// through the csr_ port (index 0..7) only while no block is in flight; the
// block does not enforce this. Each round has its own pipeline stage, so one
// block is taken into the input register every cycle while req_tready is high.
// An output register and a one-entry skid register follow the last round.
// When the receiver stalls, the skid register takes one more block, then
// req_tready drops and the whole pipe holds until the skid drains; nothing is
// lost or repeated. req_tready depends only on registered state.
// Synchronous reset clears all valid bits and the key words to zero.
//------------------------------------------------------------------------------
`default_nettype none

module feistel_64bit_block_cipher_top
   import fbc_pkg::*;
#(
   parameter int ROUND_COUNT = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [2*WORD_W-1:0]    req_tdata,   // [63:0] data_block
   input  wire logic                   req_tuser,   // [0] func
   // Result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [2*WORD_W-1:0]         rsp_tdata,   // [63:0] result_block
   // Key register write port
   input  wire logic                   csr_we,
   input  wire logic [KEY_IDX_W-1:0]   csr_index,
   input  wire logic [WORD_W-1:0]      csr_wdata
);

   logic [WORD_W-1:0]   key_ff [KEY_COUNT];
   stage_type           in_stage_ff;
   stage_type           stage_chain [ROUND_COUNT+1];
   logic                advance;
   logic                deliver;
   logic [2*WORD_W-1:0] pipe_result;
   logic                out_valid_ff;
   logic [2*WORD_W-1:0] out_data_ff;
   logic                skid_valid_ff;
   logic [2*WORD_W-1:0] skid_data_ff;

   // Key word writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_COUNT; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   // Pipe moves whenever the skid register is free
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   // Capture the incoming block
   always_ff @(posedge clock) begin
      if (reset) begin
         in_stage_ff.valid <= 1'b0;
      end else if (advance) begin
         in_stage_ff.valid <= req_tvalid;
      end
      if (advance) begin
         in_stage_ff.func <= req_tuser;
         in_stage_ff.n1   <= req_tdata[WORD_W-1:0];
         in_stage_ff.n2   <= req_tdata[2*WORD_W-1:WORD_W];
      end
   end

   assign stage_chain[0] = in_stage_ff;

   // One stage per round with a fixed key word for each mode
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      localparam logic [KEY_IDX_W-1:0] ENC_IDX = KEY_IDX_W'(r % KEY_COUNT);
      localparam logic [KEY_IDX_W-1:0] DEC_IDX =
         KEY_IDX_W'(KEY_COUNT - 1 - (r % KEY_COUNT));

      fbc_round u_round (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .key_enc  (key_ff[ENC_IDX]),
         .key_dec  (key_ff[DEC_IDX]),
         .stage_up (stage_chain[r]),
         .stage_dn (stage_chain[r+1])
      );
   end

   // Halves swap back at the end
   assign deliver     = advance && stage_chain[ROUND_COUNT].valid;
   assign pipe_result = {stage_chain[ROUND_COUNT].n1, stage_chain[ROUND_COUNT].n2};

   // Output register with skid: drain skid first, else take from the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= deliver;
         end
      end else if (deliver) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : pipe_result;
      end else if (deliver) begin
         skid_data_ff <= pipe_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // A block leaving the last round during a stall lands in the skid
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && deliver) |=> skid_valid_ff)
      else $error("block from last round dropped during output stall");

   // A taken result frees the skid in the next cycle
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid register did not drain into the output register");

endmodule

`default_nettype wire

[rtl/core/fbc_round.sv]
//------------------------------------------------------------------------------
// fbc_round: one Feistel round and its stage register
// Computes one round on the incoming slot and registers it when the pipe moves.
//------------------------------------------------------------------------------
`default_nettype none

module fbc_round
   import fbc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic [WORD_W-1:0] key_enc,
   input  wire logic [WORD_W-1:0] key_dec,
   input  wire stage_type         stage_up,
   output stage_type              stage_dn
);

   stage_type         stage_ff;
   stage_type         stage_in;
   logic [WORD_W-1:0] round_key;

   // Pick the key word by mode
   assign round_key = stage_up.func ? key_dec : key_enc;

   // Swap halves through the round function
   always_comb begin
      stage_in       = stage_up;
      stage_in.n1    = stage_up.n2 ^ round_fn(stage_up.n1, round_key);
      stage_in.n2    = stage_up.n1;
   end

   // Advance the slot, valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.func <= stage_in.func;
         stage_ff.n1   <= stage_in.n1;
         stage_ff.n2   <= stage_in.n2;
      end
   end

   assign stage_dn = stage_ff;

endmodule

`default_nettype wire
